// File: hdl/keyframe_pose_interpolator_core_assert.svh
// Assertion macros shared by the keyframe pose interpolator RTL
`ifndef KEYFRAME_POSE_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_POSE_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define KPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KPI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/kpi_pkg.sv
// Shared constants, types and helper functions of the keyframe pose interpolator
package kpi_pkg;

  localparam int NUM_COORDS  = 18;
  localparam int MAX_FRAMES  = 64;
  localparam int COORD_WIDTH = 16;

  localparam int POSE_W     = COORD_WIDTH + 8;   // Q16.8 pose
  localparam int DIFF_W     = POSE_W + 1;
  localparam int RATIO_W    = 16;                // Q0.16 ratio
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = RATIO_W / DIGIT_W;
  localparam int PROD_W     = DIFF_W + RATIO_W;
  localparam int RND_W      = POSE_W - 7;
  localparam int POS_W      = 16;
  localparam int POS_MAX    = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN    = -(2 ** (POS_W - 1));
  localparam int DUR_W      = 16;
  localparam int DIV_W      = DUR_W;
  localparam int STEP_W     = $clog2(DIV_W + 1);
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = FRAME_W + 1;
  localparam int CIDX_W     = (NUM_COORDS > 1) ? $clog2(NUM_COORDS) : 1;
  localparam int KF_DEPTH   = MAX_FRAMES * NUM_COORDS;
  localparam int KF_AW      = $clog2(KF_DEPTH);
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DUR_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP   = 2'd0,
    CFG_SWITCH = 2'd1,
    CFG_FCOUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PREP,
    ST_DIV,
    ST_RD,
    ST_CALC,
    ST_MUL,
    ST_EMIT
  } state_t;

  // request to the shared serial divider
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  init_rem;
    logic [DIV_W-1:0]  shift_in;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // round Q16.8 to nearest integer (half up) and saturate to the output range
  function automatic logic signed [POS_W-1:0] round_sat(input logic signed [POSE_W-1:0] p);
    logic signed [POSE_W:0]         sum;
    logic signed [RND_W-1:0]        rnd;
    logic signed [RND_W+POS_W-1:0]  wide;
    logic signed [POS_W-1:0]        res;
    sum  = (POSE_W+1)'(p) + (POSE_W+1)'(128);
    rnd  = RND_W'(sum >>> 8);
    wide = (RND_W+POS_W)'(rnd);
    if (wide > (RND_W+POS_W)'(POS_MAX)) begin
      res = POS_W'(POS_MAX);
    end else if (wide < (RND_W+POS_W)'(POS_MIN)) begin
      res = POS_W'(POS_MIN);
    end else begin
      res = POS_W'(wide);
    end
    return res;
  endfunction

endpackage

// File: hdl/keyframe_pose_interpolator_core.sv
// Keyframe pose interpolator: keyframe store, pose registers, sequencer and serial units
//
//  channel | direction | handshake          | beat carries
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall  | cmd, frame, coord, value, elapsed
//  out     | out       | out_valid/out_stall| coord_index, position, current_frame, last
//
// Start: 7-step serial modulo of the given frame. Tick: setup (prep, 16-step serial ratio
// divide), then per coordinate store read, calc, 4-digit multiply and output register;
// a serial modulo first when the frame advances, and no divide or multiply when the tick
// snaps to the target. A stall on out holds the sequencer at the output register; in stays
// stalled until the last beat of a tick is in the output register.
// rst_n is synchronous; pose, target frame and time left clear to zero, store is not cleared.
`include "keyframe_pose_interpolator_core_assert.svh"

module keyframe_pose_interpolator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [kpi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kpi_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [kpi_pkg::CMD_W-1:0]            in_cmd,
  input  logic [kpi_pkg::FRAME_W-1:0]          in_frame,
  input  logic [kpi_pkg::CIDX_W-1:0]           in_coord,
  input  logic signed [kpi_pkg::COORD_WIDTH-1:0] in_value,
  input  logic [kpi_pkg::DUR_W-1:0]            in_elapsed,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [kpi_pkg::CIDX_W-1:0]           out_coord_index,
  output logic signed [kpi_pkg::POS_W-1:0]     out_position,
  output logic [kpi_pkg::FRAME_W-1:0]          out_current_frame,
  output logic                                 out_last
);
  import kpi_pkg::*;

  localparam int MOD_SH = DIV_W - CNT_W;

  state_t st_r, st_nxt;

  logic [DUR_W-1:0]   step_r;
  logic [DUR_W-1:0]   switch_r;
  logic [CNT_W-1:0]   fcount_r;

  logic [DUR_W-1:0]   tl_r;
  logic [FRAME_W-1:0] tgt_frame_r;
  logic [DUR_W-1:0]   elapsed_r;
  logic               snap_r;
  logic               mod_tick_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [CIDX_W-1:0]  coord_r;
  logic signed [POSE_W-1:0] pose_r [NUM_COORDS];

  logic signed [COORD_WIDTH-1:0] kf_mem [KF_DEPTH];
  logic signed [COORD_WIDTH-1:0] kf_rdata_r;

  logic                 out_valid_r;
  logic [CIDX_W-1:0]    out_coord_index_r;
  logic signed [POS_W-1:0] out_position_r;
  logic [FRAME_W-1:0]   out_current_frame_r;
  logic                 out_last_r;

  logic [DUR_W-1:0]   eff_step;
  logic [DUR_W-1:0]   start_time;
  logic [CNT_W-1:0]   eff_count;
  logic               in_fire;
  logic               out_free;
  logic               last_coord;
  logic               snap_now;
  logic [DUR_W-1:0]   el_clamp;
  logic [CNT_W-1:0]   mod_dvd;
  logic [KF_AW-1:0]   rd_addr;
  logic [KF_AW-1:0]   wr_addr;
  logic               kf_we;
  logic               out_load;
  logic               mul_start;
  logic signed [POSE_W-1:0] pose_cur;
  logic signed [POSE_W-1:0] tgt256;
  logic signed [DIFF_W-1:0] diff;
  logic signed [POSE_W-1:0] pose_upd;

  div_req_t              div_req;
  unit_sts_t             div_sts;
  logic [DIV_W-1:0]      div_quo;
  logic [DIV_W-1:0]      div_rem;
  unit_sts_t             mul_sts;
  logic signed [PROD_W-1:0] mul_prod;

  kpi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  kpi_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .diff    (diff),
    .ratio   (ratio_r),
    .sts     (mul_sts),
    .product (mul_prod)
  );

  assign eff_step   = (step_r == '0) ? DUR_W'(1) : step_r;
  assign start_time = (switch_r > eff_step) ? switch_r : eff_step;
  always_comb begin
    if (fcount_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (fcount_r > CNT_W'(MAX_FRAMES)) begin
      eff_count = CNT_W'(MAX_FRAMES);
    end else begin
      eff_count = fcount_r;
    end
  end

  assign in_stall   = (st_r != ST_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign last_coord = (coord_r == CIDX_W'(NUM_COORDS - 1));
  assign snap_now   = (elapsed_r >= tl_r);
  assign el_clamp   = snap_now ? tl_r : elapsed_r;

  // start reduces the given frame, a tick with no time left advances the current one
  assign mod_dvd = (cmd_t'(in_cmd) == CMD_START) ? CNT_W'(in_frame)
                                                 : CNT_W'(tgt_frame_r) + CNT_W'(1);

  assign rd_addr = KF_AW'(tgt_frame_r) * KF_AW'(NUM_COORDS) + KF_AW'(coord_r);
  assign wr_addr = KF_AW'(in_frame) * KF_AW'(NUM_COORDS) + KF_AW'(in_coord);

  assign pose_cur = pose_r[coord_r];
  assign tgt256   = $signed({kf_rdata_r, 8'b0});
  assign diff     = DIFF_W'(tgt256) - DIFF_W'(pose_cur);
  assign pose_upd = pose_cur + POSE_W'(mul_prod >>> RATIO_W);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_t'(in_cmd))
            CMD_START: st_nxt = ST_MOD;
            CMD_TICK:  st_nxt = (tl_r == '0) ? ST_MOD : ST_PREP;
            default:   st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MOD:  if (div_sts.done) st_nxt = mod_tick_r ? ST_PREP : ST_IDLE;
      ST_PREP: st_nxt = snap_now ? ST_RD : ST_DIV;
      ST_DIV:  if (div_sts.done) st_nxt = ST_RD;
      ST_RD:   st_nxt = ST_CALC;
      ST_CALC: st_nxt = snap_r ? ST_EMIT : ST_MUL;
      ST_MUL:  if (mul_sts.done) st_nxt = ST_EMIT;
      ST_EMIT: if (out_free) st_nxt = last_coord ? ST_IDLE : ST_RD;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_req   = '0;
    kf_we     = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_t'(in_cmd))
            CMD_LOAD: begin
              kf_we = ((CIDX_W+1)'(in_coord) < (CIDX_W+1)'(NUM_COORDS)) &&
                      ((FRAME_W+1)'(in_frame) < (FRAME_W+1)'(MAX_FRAMES));
            end
            CMD_START, CMD_TICK: begin
              div_req.start    = (cmd_t'(in_cmd) == CMD_START) || (tl_r == '0);
              div_req.init_rem = '0;
              div_req.shift_in = DIV_W'(mod_dvd) << MOD_SH;
              div_req.steps    = STEP_W'(CNT_W);
              div_req.divisor  = DIV_W'(eff_count);
            end
            default: ;
          endcase
        end
      end
      ST_PREP: begin
        div_req.start    = !snap_now;
        div_req.init_rem = elapsed_r;
        div_req.shift_in = '0;
        div_req.steps    = STEP_W'(RATIO_W);
        div_req.divisor  = tl_r;
      end
      ST_CALC: mul_start = !snap_r;
      ST_EMIT: out_load  = out_free;
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      step_r      <= DUR_W'(20);
      switch_r    <= DUR_W'(100);
      fcount_r    <= CNT_W'(1);
      tl_r        <= '0;
      tgt_frame_r <= '0;
      snap_r      <= 1'b0;
      mod_tick_r  <= 1'b0;
      coord_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_COORDS; i++) begin
        pose_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP:   step_r   <= cfg_data;
          CFG_SWITCH: switch_r <= cfg_data;
          CFG_FCOUNT: fcount_r <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            mod_tick_r <= (cmd_t'(in_cmd) == CMD_TICK);
            // frame count may have shrunk since the last start
            if (cmd_t'(in_cmd) == CMD_TICK && tl_r != '0 &&
                CNT_W'(tgt_frame_r) >= eff_count) begin
              tgt_frame_r <= '0;
            end
          end
        end
        ST_MOD: begin
          if (div_sts.done) begin
            tgt_frame_r <= div_rem[FRAME_W-1:0];
            tl_r        <= mod_tick_r ? eff_step : start_time;
          end
        end
        ST_PREP: begin
          tl_r    <= tl_r - el_clamp;
          snap_r  <= snap_now;
          coord_r <= '0;
        end
        ST_CALC: begin
          if (snap_r) pose_r[coord_r] <= tgt256;
        end
        ST_MUL: begin
          if (mul_sts.done) pose_r[coord_r] <= pose_upd;
        end
        ST_EMIT: begin
          if (out_free) coord_r <= coord_r + CIDX_W'(1);
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_fire) begin
      elapsed_r <= (in_elapsed == '0) ? eff_step : in_elapsed;
    end
    if (st_r == ST_DIV && div_sts.done) begin
      ratio_r <= div_quo;
    end
    if (out_load) begin
      out_coord_index_r   <= coord_r;
      out_position_r      <= round_sat(pose_cur);
      out_current_frame_r <= tgt_frame_r;
      out_last_r          <= last_coord;
    end
  end

  // keyframe store
  always_ff @(posedge clk) begin
    if (kf_we) begin
      kf_mem[wr_addr] <= in_value;
    end
    kf_rdata_r <= kf_mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_coord_index   = out_coord_index_r;
  assign out_position      = out_position_r;
  assign out_current_frame = out_current_frame_r;
  assign out_last          = out_last_r;

  `KPI_ASSERT_IMP(a_out_frame_range, out_valid_r, CNT_W'(out_current_frame_r) < eff_count, "out frame beyond frame count")
  `KPI_ASSERT_NXT(a_last_to_idle, out_load && last_coord, st_r == ST_IDLE, "no return to idle after last beat")
  `KPI_ASSERT_IMP(a_div_start_free, div_req.start, !div_sts.busy, "divider restarted while busy")
  `KPI_ASSERT_IMP(a_mul_busy_state, mul_sts.busy, st_r == ST_MUL, "multiplier busy outside multiply state")

endmodule

// File: hdl/kpi_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by modulo and ratio
module kpi_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kpi_pkg::div_req_t       req,
  output kpi_pkg::unit_sts_t      sts,
  output logic [kpi_pkg::DIV_W-1:0] quotient,
  output logic [kpi_pkg::DIV_W-1:0] remainder
);
  import kpi_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  shin_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DIV_W-1:0]  dvs_r;

  logic [DIV_W:0]    trial;
  logic              fits;
  logic [DIV_W-1:0]  rem_step;

  // remainder stays below the divisor, so trial < 2*divisor
  assign trial    = {rem_r, shin_r[DIV_W-1]};
  assign fits     = trial >= {1'b0, dvs_r};
  assign rem_step = fits ? DIV_W'(trial - {1'b0, dvs_r}) : trial[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.init_rem;
      shin_r <= req.shift_in;
      dvs_r  <= req.divisor;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_step;
      shin_r <= {shin_r[DIV_W-2:0], 1'b0};
      quo_r  <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: hdl/kpi_mul.sv
// Digit-serial signed x unsigned multiplier, one 4-bit ratio digit per cycle, MSB first
module kpi_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [kpi_pkg::DIFF_W-1:0] diff,
  input  logic [kpi_pkg::RATIO_W-1:0]      ratio,
  output kpi_pkg::unit_sts_t               sts,
  output logic signed [kpi_pkg::PROD_W-1:0] product
);
  import kpi_pkg::*;

  localparam int CW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic                       busy_r;
  logic                       done_r;
  logic [CW-1:0]              cnt_r;
  logic signed [PROD_W-1:0]   acc_r;
  logic [RATIO_W-1:0]         dig_r;
  logic signed [DIFF_W-1:0]   diff_r;

  logic [DIGIT_W-1:0]         digit;
  logic signed [DIFF_W+DIGIT_W:0] pp;
  logic signed [PROD_W-1:0]   acc_step;

  assign digit    = dig_r[RATIO_W-1 -: DIGIT_W];
  assign pp       = diff_r * $signed({1'b0, digit});
  assign acc_step = (acc_r <<< DIGIT_W) + PROD_W'(pp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NUM_DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      dig_r  <= ratio;
      diff_r <= diff;
    end else if (busy_r) begin
      acc_r <= acc_step;
      dig_r <= dig_r << DIGIT_W;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = acc_r;

endmodule

// File: dv/kpi_pose_checker.sv
// Checker for the keyframe pose interpolator: tracks the pose state, predicts and compares beats
module kpi_pose_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [kpi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [kpi_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic [kpi_pkg::CMD_W-1:0]              in_cmd,
  input  logic [kpi_pkg::FRAME_W-1:0]            in_frame,
  input  logic [kpi_pkg::CIDX_W-1:0]             in_coord,
  input  logic signed [kpi_pkg::COORD_WIDTH-1:0] in_value,
  input  logic [kpi_pkg::DUR_W-1:0]              in_elapsed,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic [kpi_pkg::CIDX_W-1:0]             out_coord_index,
  input  logic signed [kpi_pkg::POS_W-1:0]       out_position,
  input  logic [kpi_pkg::FRAME_W-1:0]            out_current_frame,
  input  logic                                   out_last,
  output int                                     errors,
  output int                                     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kpi_pkg::*;

  localparam logic [DUR_W-1:0] RST_STEP   = 20;
  localparam logic [DUR_W-1:0] RST_SWITCH = 100;
  localparam logic [CNT_W-1:0] RST_FCOUNT = 1;

  typedef struct packed {
    logic [CIDX_W-1:0]       coord_index;
    logic signed [POS_W-1:0] position;
    logic [FRAME_W-1:0]      current_frame;
    logic                    last;
  } pose_beat_t;

  pose_beat_t beats_due[$];

  logic [DUR_W-1:0]              step_dur;
  logic [DUR_W-1:0]              switch_dur;
  logic [CNT_W-1:0]              frame_cnt;
  logic signed [COORD_WIDTH-1:0] keyframes [KF_DEPTH];
  logic signed [POSE_W-1:0]      pose [NUM_COORDS];
  logic [FRAME_W-1:0]            tgt_frame;
  logic [DUR_W-1:0]              time_left;

  function automatic int unsigned step_eff();
    return (step_dur == 0) ? 1 : step_dur;
  endfunction

  function automatic int unsigned count_eff();
    if (frame_cnt == 0) return 1;
    if (frame_cnt > MAX_FRAMES) return MAX_FRAMES;
    return frame_cnt;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  // one tick: maybe advance the frame, then move every coordinate toward the target
  task automatic advance_pose(input logic [DUR_W-1:0] elapsed_in);
    int unsigned step, cnt, el, tl;
    longint      ratio, tgt, diff, nxt, rounded;
    bit          snap;
    int          c;
    pose_beat_t  b;
    step = step_eff();
    cnt  = count_eff();
    el   = (elapsed_in == 0) ? step : elapsed_in;
    tl   = time_left;
    if (tl == 0) begin
      tgt_frame = FRAME_W'((int'(tgt_frame) + 1) % cnt);
      tl = step;
    end
    // frame count may have shrunk under a running transition
    if (tgt_frame >= cnt) tgt_frame = '0;
    if (el >= tl) el = tl;
    snap  = (el == tl);
    ratio = snap ? 0 : (longint'(el) << 16) / longint'(tl);
    for (c = 0; c < NUM_COORDS; c++) begin
      tgt = longint'(keyframes[int'(tgt_frame) * NUM_COORDS + c]) * 256;
      if (snap) begin
        nxt = tgt;
      end else begin
        diff = tgt - longint'(pose[c]);
        nxt  = longint'(pose[c]) + ((diff * ratio) >>> 16);
      end
      pose[c] = POSE_W'(nxt);
      rounded = (nxt + 128) >>> 8;
      if (rounded > POS_MAX) rounded = POS_MAX;
      if (rounded < POS_MIN) rounded = POS_MIN;
      b.coord_index   = CIDX_W'(c);
      b.position      = POS_W'(rounded);
      b.current_frame = tgt_frame;
      b.last          = (c == NUM_COORDS - 1);
      beats_due.push_back(b);
    end
    time_left = DUR_W'(tl - el);
  endtask

  task automatic check_beat();
    pose_beat_t want;
    if (beats_due.size() == 0) begin
      report_mismatch($sformatf("beat with nothing expected: coord %0d position %0d",
                                out_coord_index, out_position));
    end else begin
      want = beats_due.pop_front();
      if (out_coord_index !== want.coord_index)
        report_mismatch($sformatf("coord_index got %0d want %0d",
                                  out_coord_index, want.coord_index));
      if (out_position !== want.position)
        report_mismatch($sformatf("coord %0d position got %0d want %0d",
                                  want.coord_index, out_position, want.position));
      if (out_current_frame !== want.current_frame)
        report_mismatch($sformatf("coord %0d current_frame got %0d want %0d",
                                  want.coord_index, out_current_frame, want.current_frame));
      if (out_last !== want.last)
        report_mismatch($sformatf("coord %0d last got %0b want %0b",
                                  want.coord_index, out_last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_dur   = RST_STEP;
      switch_dur = RST_SWITCH;
      frame_cnt  = RST_FCOUNT;
      foreach (pose[i]) pose[i] = '0;
      tgt_frame  = '0;
      time_left  = '0;
      beats_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP:   step_dur   = cfg_data;
          CFG_SWITCH: switch_dur = cfg_data;
          CFG_FCOUNT: frame_cnt  = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) begin
        case (in_cmd)
          CMD_LOAD: begin
            if (in_coord < NUM_COORDS && in_frame < MAX_FRAMES)
              keyframes[int'(in_frame) * NUM_COORDS + int'(in_coord)] = in_value;
          end
          CMD_START: begin
            tgt_frame = FRAME_W'(int'(in_frame) % count_eff());
            time_left = (switch_dur > step_eff()) ? switch_dur : DUR_W'(step_eff());
          end
          CMD_TICK: advance_pose(in_elapsed);
          default: ;
        endcase
      end
    end
    pending <= beats_due.size();
  end

endmodule

// File: dv/tb_keyframe_pose_interpolator_core.sv
// Testbench top for the keyframe pose interpolator: clock, reset, stimulus and verdict
module tb_keyframe_pose_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import kpi_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 64;    // covers a start's serial modulo and a tick's setup
  localparam int HOLD_CYCLES  = 600;
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_ITEMS  = 30;
  localparam int FILL_FRAMES  = 4;     // random phases keep the frame count within these
  localparam int FAR_FRAME    = 40;
  localparam int COORD_FIELD_MAX = 2 ** CIDX_W - 1;
  localparam int FCOUNT_FIELD_MAX = 2 ** CNT_W - 1;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [CMD_W-1:0]              in_cmd;
  logic [FRAME_W-1:0]            in_frame;
  logic [CIDX_W-1:0]             in_coord;
  logic signed [COORD_WIDTH-1:0] in_value;
  logic [DUR_W-1:0]              in_elapsed;
  logic                          out_valid;
  logic                          out_stall;
  logic [CIDX_W-1:0]             out_coord_index;
  logic signed [POS_W-1:0]       out_position;
  logic [FRAME_W-1:0]            out_current_frame;
  logic                          out_last;

  int          fail_count;
  int          beats_pending;
  int          cycle_count;
  bit          idle_on;
  bit          pressure_go;
  logic        hold_out;
  int unsigned cur_step;

  keyframe_pose_interpolator_core u_top (.*);

  kpi_pose_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_frame          (in_frame),
    .in_coord          (in_coord),
    .in_value          (in_value),
    .in_elapsed        (in_elapsed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_coord_index   (out_coord_index),
    .out_position      (out_position),
    .out_current_frame (out_current_frame),
    .out_last          (out_last),
    .errors            (fail_count),
    .pending           (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // long receiver hold so the block fills up and stalls its input
  initial begin
    hold_out = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  // receiver: calm stretches, short bursts of stall, now and then a long one
  initial begin
    int burst_left, calm_left, r;
    bit stall_now;
    out_stall  = 1'b0;
    burst_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk);
      stall_now = 1'b0;
      if (burst_left > 0) begin
        burst_left--;
        stall_now = 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) calm_left = $urandom_range(1, 40);
        else if (r < 85) burst_left = $urandom_range(1, 3);
        else if (r < 97) burst_left = $urandom_range(4, 12);
        else burst_left = $urandom_range(20, 60);
      end
      out_stall <= hold_out || stall_now;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4: return DUR_W'($urandom_range(1, cur_step));
      5, 6:    return DUR_W'($urandom_range(1, 8));
      7:       return DUR_W'($urandom);
      8:       return '1;
      default: return DUR_W'($urandom_range(1, 300));
    endcase
  endfunction

  // present one beat and hold it until accepted; returns at the accepting edge
  task automatic send_beat(input int unsigned cmd, input int unsigned frame,
                           input int unsigned coord,
                           input int unsigned value,
                           input int unsigned elapsed);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= CMD_W'(cmd);
    in_frame   <= FRAME_W'(frame);
    in_coord   <= CIDX_W'(coord);
    in_value   <= COORD_WIDTH'(value);
    in_elapsed <= DUR_W'(elapsed);
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, let every expected beat drain, then give the block time to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the pending count take in the beat just accepted first
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_STEP) cur_step = (data == 0) ? 1 : data;
  endtask

  initial begin
    int f, c, p, n, r;
    logic [CFG_DATA_W-1:0] step_w, switch_w, count_w;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_STEP;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_cmd      = CMD_LOAD;
    in_frame    = '0;
    in_coord    = '0;
    in_value    = '0;
    in_elapsed  = '0;
    idle_on     = 1'b1;
    pressure_go = 1'b0;
    cur_step    = 20;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // fill every frame a tick can reach: the low frames, the far start frame and the top one;
    // frames 0 and 1 carry the coordinate extremes
    for (f = 0; f < MAX_FRAMES; f++) begin
      if (f < FILL_FRAMES || f == FAR_FRAME || f == MAX_FRAMES - 1) begin
        for (c = 0; c < NUM_COORDS; c++) begin
          send_beat(CMD_LOAD, f, c,
                    (f == 0) ? ((c % 3 == 0) ? 16'h7FFF : (c % 3 == 1) ? 16'h8000 : 16'h0000) :
                    (f == 1) ? ((c % 2 == 0) ? 16'h8000 : 16'h7FFF) : COORD_WIDTH'($urandom),
                    $urandom);
        end
      end
    end

    // directed: reset settings, one frame
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd0);   // advance from zero time left
    send_beat(CMD_LOAD, 2, NUM_COORDS, $urandom, $urandom);      // coord out of range
    send_beat(CMD_LOAD, 3, COORD_FIELD_MAX, $urandom, $urandom);
    send_beat(CMD_RESERVED, $urandom, $urandom, $urandom, $urandom);
    send_beat(CMD_START, MAX_FRAMES - 1, $urandom, $urandom, $urandom); // reduced modulo one
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd1);
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'hFFFF); // clamped, snaps
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd0);
    wait_idle();

    write_reg(CFG_STEP, 7);
    write_reg(CFG_SWITCH, 0);
    write_reg(CFG_FCOUNT, MAX_FRAMES);
    send_beat(CMD_START, MAX_FRAMES - 1, $urandom, $urandom, $urandom);
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd3);
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd4);    // exactly the time left
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd0);    // wraps to frame 0
    send_beat(CMD_LOAD, 1, NUM_COORDS - 1, 16'h8000, $urandom);
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd2);    // partial step into frame 1
    wait_idle();

    write_reg(CFG_STEP, 0);
    write_reg(CFG_SWITCH, 16'hFFFF);
    write_reg(CFG_FCOUNT, 0);
    send_beat(CMD_START, 9, $urandom, $urandom, $urandom);
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd0);    // zero step taken as one
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd65533);
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd0);
    wait_idle();

    write_reg(CFG_FCOUNT, FCOUNT_FIELD_MAX);
    write_reg(CFG_STEP, 16'hFFFF);
    write_reg(CFG_SWITCH, 300);
    send_beat(CMD_START, FAR_FRAME, $urandom, $urandom, $urandom);
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd100);
    wait_idle();

    // target frame now beyond the count: falls back to frame 0
    write_reg(CFG_FCOUNT, 5);
    send_beat(CMD_TICK, $urandom, $urandom, $urandom, 16'd0);
    wait_idle();

    for (p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 6))
        0:       step_w = 0;
        1:       step_w = 1;
        2:       step_w = 16'hFFFF;
        3:       step_w = CFG_DATA_W'($urandom);
        default: step_w = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 5))
        0:       switch_w = 0;
        1:       switch_w = 16'hFFFF;
        2:       switch_w = CFG_DATA_W'($urandom);
        default: switch_w = $urandom_range(0, 150);
      endcase
      case ($urandom_range(0, 3))
        0:       count_w = 0;
        1:       count_w = 1;
        default: count_w = $urandom_range(2, FILL_FRAMES);
      endcase
      write_reg(CFG_STEP, step_w);
      write_reg(CFG_SWITCH, switch_w);
      write_reg(CFG_FCOUNT, count_w);
      idle_on = ($urandom_range(0, 3) != 0);
      if (p == 0) begin
        idle_on     = 1'b0;
        pressure_go = 1'b1;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 6)
          send_beat(CMD_RESERVED, $urandom, $urandom, $urandom, $urandom);
        else if (r < 10)
          send_beat(CMD_LOAD, $urandom, $urandom_range(NUM_COORDS, COORD_FIELD_MAX),
                    $urandom, $urandom);
        else if (r < 25)
          send_beat(CMD_LOAD, $urandom, $urandom_range(0, NUM_COORDS - 1), pick_value(),
                    $urandom);
        else if (r < 40)
          send_beat(CMD_START, $urandom, $urandom, $urandom, $urandom);
        else
          send_beat(CMD_TICK, $urandom, $urandom, $urandom, pick_elapsed());
      end
      wait_idle();
    end

    if (fail_count == 0 && beats_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
